// ===== design/crwf_pkg.sv =====
// crwf_pkg: shared types and constants of the repeat window filter
// word layouts of the input and result channels, field widths, register map
// no dependencies; used by crwf_front, crwf_back, the top level and the testbench

package crwf_pkg;

  // field widths of the channel words
  localparam int CLOCK_W = 48;
  localparam int CARD_W  = 5;
  localparam int CHAN_W  = 3;
  localparam int WIN_W   = 24;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WINDOW = 1'b0
  } reg_idx_e;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 24'd25000;

  // action codes of an input word
  typedef enum logic {
    ACT_HIT     = 1'b0,
    ACT_TRIGGER = 1'b1
  } action_e;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic              action;
    logic [CLOCK_W-1:0] trigger_clock;
    logic [CARD_W-1:0] card_number;
    logic [CHAN_W-1:0] channel_number;
  } in_word_t;

  typedef struct packed {
    logic               keep_hit;
    logic [CLOCK_W-1:0] hit_time;
    logic               table_overflow;
  } out_word_t;

endpackage

// ===== design/crwf_stream_if.sv =====
// crwf_stream_if: valid/ready channel carrying one word per handshake
// payload type is a parameter; instances use crwf_pkg word types

interface crwf_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== design/crwf_ram.sv =====
// crwf_ram: generic single-write, single-read memory with registered read
// no dependencies

module crwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/crwf_fifo.sv =====
// crwf_fifo: short word queue between the front and back parts
// no dependencies

module crwf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] nxt;
    if (ptr == PTR_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + PTR_W'(1);
    end
    return nxt;
  endfunction

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/crwf_front.sv =====
// crwf_front: accepts input words, keeps the event time, stamps hits
// depends on crwf_pkg; feeds the hit queue

module crwf_front #(
  parameter int TIME_BITS = 48
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  crwf_pkg::in_word_t                           in_word_i,
  output logic                                         push_valid_o,
  input  logic                                         push_ready_i,
  output logic [TIME_BITS+crwf_pkg::CARD_W+crwf_pkg::CHAN_W-1:0] push_data_o
);

  logic [TIME_BITS-1:0] current_time_q, current_time_d;
  logic                 is_trigger;

  assign is_trigger = (in_word_i.action == crwf_pkg::ACT_TRIGGER);

  // one word taken whenever the queue has room
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && !is_trigger;
  assign push_data_o  = {current_time_q, in_word_i.card_number, in_word_i.channel_number};

  // trigger words set the event time
  always_comb begin
    current_time_d = current_time_q;
    if (in_valid_i && in_ready_o && is_trigger) begin
      current_time_d = TIME_BITS'(in_word_i.trigger_clock);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_time_q <= '0;
    end else begin
      current_time_q <= current_time_d;
    end
  end

endmodule

// ===== design/crwf_back.sv =====
// crwf_back: scans the hit table for each queued hit, then stores the hit
// depends on crwf_pkg and crwf_ram; drives the result register

module crwf_back #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         pop_valid_i,
  output logic                                         pop_ready_o,
  input  logic [TIME_BITS+crwf_pkg::CARD_W+crwf_pkg::CHAN_W-1:0] pop_data_i,
  input  logic [crwf_pkg::WIN_W-1:0]                   window_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output crwf_pkg::out_word_t                          out_word_o
);

  localparam int CARD_W     = crwf_pkg::CARD_W;
  localparam int CHAN_W     = crwf_pkg::CHAN_W;
  localparam int OUT_TIME_W = crwf_pkg::CLOCK_W;
  localparam int ENTRY_W    = TIME_BITS + CARD_W + CHAN_W;
  localparam int IDX_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int CMP_W      = (TIME_BITS > crwf_pkg::WIN_W) ? TIME_BITS : crwf_pkg::WIN_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } back_state_e;

  back_state_e          state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [TIME_BITS-1:0] t_q;
  logic [CARD_W-1:0]    card_q;
  logic [CHAN_W-1:0]    chan_q;
  logic                 noise_q, noise_d;
  logic                 free_found_q, free_found_d;
  logic [IDX_W-1:0]     free_slot_q, free_slot_d;
  logic                 min_any_q, min_any_d;
  logic [TIME_BITS-1:0] min_time_q, min_time_d;
  logic [IDX_W-1:0]     min_slot_q, min_slot_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic                 out_valid_q, out_valid_d;
  crwf_pkg::out_word_t  out_word_q;

  logic                 pop;
  logic                 proc_en;
  logic [IDX_W-1:0]     proc_idx;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENTRY_W-1:0]   rd_entry;
  logic [TIME_BITS-1:0] et;
  logic [CARD_W-1:0]    ec;
  logic [CHAN_W-1:0]    ech;
  logic                 ge, in_win, stale, alive, match;
  logic [TIME_BITS-1:0] diff;
  logic                 do_write;
  logic [IDX_W-1:0]     wr_slot;

  assign pop         = (state_q == ST_IDLE) && pop_valid_i;
  assign pop_ready_o = (state_q == ST_IDLE);

  // table storage, read one entry a cycle during the scan
  assign rd_addr = (cnt_q < CNT_W'(TABLE_DEPTH)) ? IDX_W'(cnt_q) : '0;

  crwf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (wr_slot),
    .wdata_i ({t_q, card_q, chan_q}),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  // entry under test is the one addressed in the previous cycle
  assign proc_en  = (state_q == ST_SCAN) && (cnt_q != '0);
  assign proc_idx = IDX_W'(cnt_q - CNT_W'(1));
  assign et       = rd_entry[ENTRY_W-1 -: TIME_BITS];
  assign ec       = rd_entry[CHAN_W +: CARD_W];
  assign ech      = rd_entry[CHAN_W-1:0];

  // symmetric window test and staleness
  assign ge     = (t_q >= et);
  assign diff   = ge ? (t_q - et) : (et - t_q);
  assign in_win = (CMP_W'(diff) <= CMP_W'(window_i));
  assign stale  = valid_q[proc_idx] && ge && !in_win;
  assign alive  = valid_q[proc_idx] && !stale;
  assign match  = (ec == card_q) && (ech == chan_q);

  // store slot: lowest free entry, else the oldest one
  assign do_write = (state_q == ST_WRITE) && (!out_valid_q || out_ready_i);
  assign wr_slot  = free_found_q ? free_slot_q : min_slot_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    noise_d      = noise_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    min_any_d    = min_any_q;
    min_time_d   = min_time_q;
    min_slot_d   = min_slot_q;
    valid_d      = valid_q;
    out_valid_d  = out_valid_q;

    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          state_d      = ST_SCAN;
          cnt_d        = '0;
          noise_d      = 1'b0;
          free_found_d = 1'b0;
          min_any_d    = 1'b0;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
          state_d = ST_WRITE;
        end
        if (proc_en) begin
          if (stale) begin
            valid_d[proc_idx] = 1'b0;
          end
          if (alive && in_win && match) begin
            noise_d = 1'b1;
          end
          if (!alive && !free_found_q) begin
            free_found_d = 1'b1;
            free_slot_d  = proc_idx;
          end
          if (alive && (!min_any_q || (et < min_time_q))) begin
            min_any_d  = 1'b1;
            min_time_d = et;
            min_slot_d = proc_idx;
          end
        end
      end
      ST_WRITE: begin
        if (do_write) begin
          state_d = ST_IDLE;
          valid_d[wr_slot] = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // result register: freed when taken, loaded by the store
    if (do_write) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      noise_q      <= 1'b0;
      free_found_q <= 1'b0;
      min_any_q    <= 1'b0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      noise_q      <= noise_d;
      free_found_q <= free_found_d;
      min_any_q    <= min_any_d;
      valid_q      <= valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // hit under test, scan results and result word
  always_ff @(posedge clk_i) begin
    if (pop) begin
      t_q    <= pop_data_i[ENTRY_W-1 -: TIME_BITS];
      card_q <= pop_data_i[CHAN_W +: CARD_W];
      chan_q <= pop_data_i[CHAN_W-1:0];
    end
    free_slot_q <= free_slot_d;
    min_time_q  <= min_time_d;
    min_slot_q  <= min_slot_d;
    if (do_write) begin
      out_word_q.keep_hit       <= !noise_q;
      out_word_q.hit_time       <= OUT_TIME_W'(t_q);
      out_word_q.table_overflow <= !free_found_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // an overwrite only happens on a full table
  a_overwrite_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_write && !free_found_q) |-> (&valid_q))
    else $error("oldest entry overwritten while a slot was free");

  // the scan ends after the last entry
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && (cnt_q == CNT_W'(TABLE_DEPTH))) |=> (state_q == ST_WRITE))
    else $error("scan did not hand over to the store step");

  // a stored hit leaves its slot valid
  a_store_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write |=> valid_q[$past(wr_slot)])
    else $error("stored slot not marked valid");

  // a result appears only after a store
  a_result_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(do_write))
    else $error("result raised without a store");

endmodule

// ===== design/channel_repeat_window_filter.sv =====
// channel_repeat_window_filter: top level of the repeat window filter
// depends on crwf_pkg, crwf_stream_if, crwf_front, crwf_fifo, crwf_back
//
//   channel  dir  word                 handshake
//   in_i     in   crwf_pkg::in_word_t  valid/ready
//   out_o    out  crwf_pkg::out_word_t valid/ready
//   apb      in   window_ticks reg     psel/penable/pwrite, pready tied high
//
// a trigger word is taken whenever the hit queue has room and only updates the event time
// in the back part a hit is tested against every table entry, then stored: one
//   table entry is read per cycle from the single-read table memory
// the front keeps taking words while the hit queue has room; a waiting result
//   stalls only the store step of the next hit
// after reset the table is empty at once (per-entry valid bits), no clearing pass

module channel_repeat_window_filter #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  crwf_stream_if.sink                     in_i,
  crwf_stream_if.source                   out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [crwf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [crwf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [crwf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int QW = TIME_BITS + crwf_pkg::CARD_W + crwf_pkg::CHAN_W;

  logic [crwf_pkg::WIN_W-1:0]     window_q, window_d;
  logic [crwf_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           push_valid, push_ready;
  logic [QW-1:0]                  push_data;
  logic                           pop_valid, pop_ready;
  logic [QW-1:0]                  pop_data;

  // configuration register
  assign pready  = 1'b1;
  assign reg_idx = paddr[crwf_pkg::APB_ADDR_W-1:2];

  always_comb begin
    window_d = window_q;
    if (psel && penable && pwrite && pready &&
        (reg_idx == crwf_pkg::REG_WINDOW)) begin
      window_d = pwdata[crwf_pkg::WIN_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      crwf_pkg::REG_WINDOW: prdata = crwf_pkg::APB_DATA_W'(window_q);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= crwf_pkg::WINDOW_RESET;
    end else begin
      window_q <= window_d;
    end
  end

  // front: takes words, stamps hits
  crwf_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_word_i    (in_i.payload),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // hit queue
  crwf_fifo #(
    .WIDTH (QW),
    .DEPTH (crwf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // back: table scan and store
  crwf_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .window_i    (window_q),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_o.payload)
  );

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for channel_repeat_window_filter
// predicts hit stamping, window pruning, repeat tagging and table overflow per word
// depends on crwf_pkg, crwf_stream_if and channel_repeat_window_filter from the design folder

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crwf_pkg::*;

  localparam int SLOTS          = 16;
  localparam int STAMP_W        = 48;
  localparam int MAX_WAIT       = 17;
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_AT_WORD   = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASE_WORDS    = 165;

  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW   = {REG_WINDOW, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
  localparam logic [CLOCK_W-1:0]    CLOCK_MAX     = {CLOCK_W{1'b1}};
  localparam logic [WIN_W-1:0]      WINDOW_MAX    = {WIN_W{1'b1}};

  logic clk_i = 1'b0;
  logic rst_n = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  crwf_stream_if #(.payload_t(in_word_t))  in_ch  ();
  crwf_stream_if #(.payload_t(out_word_t)) out_ch ();

  channel_repeat_window_filter #(
    .TABLE_DEPTH(SLOTS),
    .TIME_BITS  (STAMP_W)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #10 clk_i = ~clk_i;

  // predicted filter state
  logic [WIN_W-1:0]   window_len;
  logic [CLOCK_W-1:0] event_clock;
  logic [CLOCK_W-1:0] slot_time [SLOTS];
  logic [CARD_W-1:0]  slot_card [SLOTS];
  logic [CHAN_W-1:0]  slot_chan [SLOTS];
  logic               slot_used [SLOTS];

  in_word_t  pending_words [$];
  out_word_t expected_hits [$];

  int words_queued = 0;
  int words_taken;
  int errors = 0;
  int gap_left;
  int stall_left;
  int hold_left;
  int idle_cycles;
  bit hold_done;
  bit src_quiet;
  bit snk_quiet;

  logic [CLOCK_W-1:0] base_clock = '0;

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  task automatic flag_error(string msg);
    if (errors < REPORT_LIMIT) $display("%t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // trigger sets the event clock; a hit is stamped, tested against the table and stored
  task automatic stamp_and_filter(input in_word_t w);
    logic [CLOCK_W-1:0] t;
    logic [CLOCK_W-1:0] diff;
    logic               noisy;
    logic               over;
    int                 slot;
    out_word_t          res;
    if (w.action == ACT_TRIGGER) begin
      event_clock = w.trigger_clock;
    end else begin
      t     = event_clock;
      noisy = 1'b0;
      over  = 1'b0;
      slot  = -1;
      // prune stale entries, look for a repeat in either direction
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i]) begin
          if (t > slot_time[i] && (t - slot_time[i]) > window_len) begin
            slot_used[i] = 1'b0;
          end else begin
            diff = (t >= slot_time[i]) ? t - slot_time[i] : slot_time[i] - t;
            if (diff <= window_len && slot_card[i] == w.card_number &&
                slot_chan[i] == w.channel_number)
              noisy = 1'b1;
          end
        end
      end
      // lowest free slot, else the oldest entry with ties to the lowest slot
      for (int i = 0; i < SLOTS && slot < 0; i++)
        if (!slot_used[i]) slot = i;
      if (slot < 0) begin
        slot = 0;
        for (int i = 1; i < SLOTS; i++)
          if (slot_time[i] < slot_time[slot]) slot = i;
        over = 1'b1;
      end
      slot_time[slot] = t;
      slot_card[slot] = w.card_number;
      slot_chan[slot] = w.channel_number;
      slot_used[slot] = 1'b1;
      res.keep_hit       = ~noisy;
      res.hit_time       = t;
      res.table_overflow = over;
      expected_hits.push_back(res);
    end
  endtask

  // input side: one word in flight, random gap after each accepted word
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.payload <= '0;
      gap_left      <= 0;
      src_quiet     <= 1'b0;
      words_taken   <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        stamp_and_filter(in_ch.payload);
        words_taken <= words_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          in_ch.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (pending_words.size() != 0) begin
          in_ch.payload <= pending_words.pop_front();
          in_ch.valid   <= 1'b1;
          gap_left      <= draw_wait(src_quiet);
          if ($urandom_range(0, 39) == 0) src_quiet <= ~src_quiet;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once, so the hit queue fills and the input stalls
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_taken >= HOLD_AT_WORD) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result side: compare against the oldest prediction, random stall per word
  always @(posedge clk_i or negedge rst_n) begin : result_side
    int        stall_draw;
    out_word_t want;
    out_word_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
      snk_quiet    <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (expected_hits.size() == 0) begin
          flag_error($sformatf("unexpected word keep=%0d time=%0h ovf=%0d",
                               got.keep_hit, got.hit_time, got.table_overflow));
        end else begin
          want = expected_hits.pop_front();
          if (got.keep_hit !== want.keep_hit || got.hit_time !== want.hit_time ||
              got.table_overflow !== want.table_overflow)
            flag_error($sformatf(
              "expected keep=%0d time=%0h ovf=%0d, actual keep=%0d time=%0h ovf=%0d",
              want.keep_hit, want.hit_time, want.table_overflow,
              got.keep_hit, got.hit_time, got.table_overflow));
        end
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        stall_draw   = draw_wait(snk_quiet);
        stall_left   <= stall_draw;
        out_ch.ready <= (stall_draw == 0);
        if ($urandom_range(0, 39) == 0) snk_quiet <= ~snk_quiet;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= (stall_left == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_trigger(input logic [CLOCK_W-1:0] stamp);
    in_word_t w;
    w.action         = ACT_TRIGGER;
    w.trigger_clock  = stamp;
    w.card_number    = CARD_W'($urandom);
    w.channel_number = CHAN_W'($urandom);
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_hit(input logic [CARD_W-1:0] card, input logic [CHAN_W-1:0] chan);
    in_word_t w;
    w.action         = ACT_HIT;
    w.trigger_clock  = CLOCK_W'({$urandom, $urandom});
    w.card_number    = card;
    w.channel_number = chan;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // register write: setup cycle then access cycle
  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_WINDOW) window_len = data[WIN_W-1:0];
  endtask

  task automatic wait_idle();
    while (words_taken != words_queued || expected_hits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly trigger-then-hit bursts around a moving base clock, some jumps and noise
  task automatic random_phase(input int count);
    int                 made;
    int                 pick;
    int                 hits;
    int unsigned        span;
    logic [CARD_W-1:0]  card_base;
    logic [CLOCK_W-1:0] stamp;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      span = (window_len == 0) ? 1 : 2 * int'(window_len);
      if (pick < 70) begin
        if ($urandom_range(0, 1) == 0) begin
          base_clock = base_clock + CLOCK_W'($urandom_range(0, span));
          stamp      = base_clock;
        end else begin
          stamp = base_clock + CLOCK_W'($urandom_range(0, 2 * span)) - CLOCK_W'(span);
        end
        push_trigger(stamp);
        hits      = $urandom_range(1, 20);
        card_base = CARD_W'($urandom);
        for (int i = 0; i < hits; i++)
          push_hit(card_base + CARD_W'($urandom_range(0, 2)),
                   ($urandom_range(0, 2) == 0) ? CHAN_W'($urandom) :
                                                 CHAN_W'($urandom_range(0, 1)));
        made += 1 + hits;
      end else if (pick < 80) begin
        case ($urandom_range(0, 2))
          0: base_clock = '0;
          1: base_clock = CLOCK_MAX - CLOCK_W'($urandom_range(0, 3));
          default: base_clock = CLOCK_W'({$urandom, $urandom});
        endcase
        push_trigger(base_clock);
        made++;
      end else begin
        if ($urandom_range(0, 1) == 0) push_trigger(CLOCK_W'({$urandom, $urandom}));
        else push_hit(CARD_W'($urandom), CHAN_W'($urandom));
        made++;
      end
    end
  endtask

  initial begin
    logic [WIN_W-1:0] settings [5];
    window_len  = WINDOW_RESET;
    event_clock = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_time[i] = '0;
      slot_card[i] = '0;
      slot_chan[i] = '0;
      slot_used[i] = 1'b0;
    end
    rst_n <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // hits before any trigger carry time zero; a repeat at once
    push_hit(5'd0, 3'd0);
    push_hit(5'd31, 3'd7);
    push_hit(5'd0, 3'd0);
    // exactly on the window edge
    push_trigger(CLOCK_W'(WINDOW_RESET));
    push_hit(5'd0, 3'd0);
    // one past the edge: the zero-time entries go stale
    push_trigger(CLOCK_W'(WINDOW_RESET) + 1);
    push_hit(5'd31, 3'd7);
    // clock going backwards: repeat against a future entry
    push_trigger(CLOCK_W'(10));
    push_hit(5'd0, 3'd0);
    // largest clock, then back to zero with a far future entry kept
    push_trigger(CLOCK_MAX);
    push_hit(5'd5, 3'd3);
    push_trigger('0);
    push_hit(5'd5, 3'd3);
    // twelve more hits at time zero; the table then holds 14 of its 16 entries, none overwritten
    for (int i = 0; i < 12; i++) push_hit(CARD_W'(i + 8), CHAN_W'(i));
    wait_idle();
    random_phase(PHASE_WORDS);

    // window settings, extremes included; spare upper data bits set at random
    settings[0] = '0;
    settings[1] = WINDOW_MAX;
    settings[2] = WIN_W'(1);
    settings[3] = WIN_W'($urandom_range(2, 200000));
    settings[4] = WINDOW_RESET;
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      if (p == 1) apb_write(ADDR_UNMAPPED, $urandom);
      apb_write(ADDR_WINDOW, {8'($urandom), settings[p]});
      random_phase(PHASE_WORDS);
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
